/* sv/tgq_pkg.sv */
package tgq_pkg;

    // field widths fixed by the interface
    localparam int RAW_W  = 12;
    localparam int TIME_W = 32;
    localparam int DEB_W  = 16;
    localparam int CFG_W  = 16;
    localparam int GS_W   = 2;
    localparam int XPOS_W = 9;
    localparam int YPOS_W = 8;

    // an axis must change by more than this to count as a move
    localparam int MOVE_THRESHOLD = 5;

    // gesture codes as seen on the output
    localparam logic [GS_W-1:0] GS_IDLE = 2'd0;
    localparam logic [GS_W-1:0] GS_DOWN = 2'd1;
    localparam logic [GS_W-1:0] GS_MOVE = 2'd2;
    localparam logic [GS_W-1:0] GS_UP   = 2'd3;

    typedef enum logic [2:0] {
        CFG_CAL_X_MIN    = 3'd0,
        CFG_CAL_X_MAX    = 3'd1,
        CFG_CAL_Y_MIN    = 3'd2,
        CFG_CAL_Y_MAX    = 3'd3,
        CFG_MIN_PRESSURE = 3'd4,
        CFG_MAX_PRESSURE = 3'd5,
        CFG_INVERT_AXES  = 3'd6,
        CFG_DEBOUNCE_MS  = 3'd7
    } cfg_index_t;

endpackage

/* sv/tgq_in_if.sv */
interface tgq_in_if;
    import tgq_pkg::*;

    logic              valid;
    logic              ready;
    logic              touched;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [RAW_W-1:0]  raw_pressure;
    logic [TIME_W-1:0] now_ms;

    modport source (
        output valid, touched, raw_x, raw_y, raw_pressure, now_ms,
        input  ready
    );

    modport sink (
        input  valid, touched, raw_x, raw_y, raw_pressure, now_ms,
        output ready
    );

endinterface

/* sv/tgq_out_if.sv */
interface tgq_out_if;
    import tgq_pkg::*;

    logic              valid;
    logic              ready;
    logic [GS_W-1:0]   gesture_state;
    logic [XPOS_W-1:0] x_pos;
    logic [YPOS_W-1:0] y_pos;
    logic [RAW_W-1:0]  pressure_out;
    logic              point_valid;

    modport source (
        output valid, gesture_state, x_pos, y_pos, pressure_out, point_valid,
        input  ready
    );

    modport sink (
        input  valid, gesture_state, x_pos, y_pos, pressure_out, point_valid,
        output ready
    );

endinterface

/* sv/tgq_axis.sv */
module tgq_axis #(
    parameter int SIZE = 320
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tgq_pkg::RAW_W-1:0]     raw,
    input  logic [tgq_pkg::RAW_W-1:0]     cal_lo,
    input  logic [tgq_pkg::RAW_W-1:0]     cal_hi,
    input  logic                          invert,
    output logic                          busy,
    output logic [$clog2(SIZE)-1:0]       coord
);
    import tgq_pkg::*;

    localparam int CW    = $clog2(SIZE);
    // |raw - lo| * SIZE stays below 2^(RAW_W + CW)
    localparam int NW    = RAW_W + CW;
    localparam int CNT_W = $clog2(NW + 1);

    typedef enum logic [3:0] {
        AX_IDLE = 4'b0001,
        AX_MUL  = 4'b0010,
        AX_DIV  = 4'b0100,
        AX_FIX  = 4'b1000
    } ax_state_t;

    ax_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RAW_W-1:0]   dmag_reg, dmag_next;
    logic [RAW_W-1:0]   smag_reg, smag_next;
    logic               neg_reg, neg_next;
    logic               zero_reg, zero_next;
    logic               invert_reg, invert_next;
    logic [NW-1:0]      quo_reg, quo_next;
    logic [RAW_W-1:0]   rem_reg, rem_next;
    logic [CW-1:0]      coord_reg, coord_next;

    logic [RAW_W:0]     diff;
    logic [RAW_W:0]     span;
    logic [RAW_W:0]     trial;
    logic               trial_ge;
    logic [NW-1:0]      quo_fix;
    logic               neg_fix;
    logic               over_fix;

    assign diff     = {1'b0, raw} - {1'b0, cal_lo};
    assign span     = {1'b0, cal_hi} - {1'b0, cal_lo};

    // restoring division, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[NW-1]};
    assign trial_ge = trial >= {1'b0, smag_reg};

    // zero span maps to zero; a negative quotient of zero is plain zero
    assign quo_fix  = zero_reg ? '0 : quo_reg;
    assign neg_fix  = neg_reg && (quo_fix != '0);
    assign over_fix = quo_fix >= NW'(SIZE);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        dmag_next   = dmag_reg;
        smag_next   = smag_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        invert_next = invert_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        coord_next  = coord_reg;
        case (state_reg)
            AX_IDLE:
            begin
                if (start)
                begin
                    dmag_next   = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
                    smag_next   = span[RAW_W] ? RAW_W'(-span) : span[RAW_W-1:0];
                    neg_next    = diff[RAW_W] ^ span[RAW_W];
                    zero_next   = (span == '0);
                    invert_next = invert;
                    state_next  = AX_MUL;
                end
            end
            AX_MUL:
            begin
                quo_next   = NW'(dmag_reg) * NW'(SIZE);
                rem_next   = '0;
                cnt_next   = CNT_W'(NW);
                state_next = AX_DIV;
            end
            AX_DIV:
            begin
                rem_next = trial_ge ? RAW_W'(trial - {1'b0, smag_reg}) : trial[RAW_W-1:0];
                quo_next = {quo_reg[NW-2:0], trial_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = AX_FIX;
                end
            end
            AX_FIX:
            begin
                // sign, mirror and clamp without a signed intermediate
                if (!invert_reg)
                begin
                    if (neg_fix)
                        coord_next = '0;
                    else if (over_fix)
                        coord_next = CW'(SIZE - 1);
                    else
                        coord_next = quo_fix[CW-1:0];
                end
                else
                begin
                    if (neg_fix)
                        coord_next = CW'(SIZE - 1);
                    else if (over_fix)
                        coord_next = '0;
                    else
                        coord_next = CW'(NW'(SIZE - 1) - quo_fix);
                end
                state_next = AX_IDLE;
            end
            default:
            begin
                state_next = AX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AX_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_reg   <= dmag_next;
        smag_reg   <= smag_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        invert_reg <= invert_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        coord_reg  <= coord_next;
    end

    assign busy  = (state_reg != AX_IDLE);
    assign coord = coord_reg;

endmodule

/* sv/touch_gesture_qualifier_unit.sv */
// channel  | role   | handshake      | payload
// in_ch    | sink   | valid / ready  | touched, raw_x, raw_y, raw_pressure, now_ms
// out_ch   | source | valid / ready  | gesture_state, x_pos, y_pos, pressure_out, point_valid
// cfg      | write  | cfg_wr_en      | cfg_index, cfg_data
//
// one word in gives one word out, once the bit-serial dividers of both axes are done
// a new word can be taken in the same cycle that the previous result is registered
// reset restores the calibration defaults, idles the gesture and zeroes the point
// a stalled result sits in the output register while the next word computes;
// that word then waits for the result to be taken before it updates state
module touch_gesture_qualifier_unit #(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 240
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  tgq_pkg::cfg_index_t         cfg_index,
    input  logic [tgq_pkg::CFG_W-1:0]   cfg_data,
    tgq_in_if.sink                      in_ch,
    tgq_out_if.source                   out_ch
);
    import tgq_pkg::*;

    localparam int XW = $clog2(SCREEN_W);
    localparam int YW = $clog2(SCREEN_H);

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_CALC = 2'b10
    } top_state_t;

    typedef enum logic [3:0] {
        G_IDLE = 4'b0001,
        G_DOWN = 4'b0010,
        G_MOVE = 4'b0100,
        G_UP   = 4'b1000
    } gesture_t;

    // configuration registers
    logic [RAW_W-1:0]  cal_x_min_reg;
    logic [RAW_W-1:0]  cal_x_max_reg;
    logic [RAW_W-1:0]  cal_y_min_reg;
    logic [RAW_W-1:0]  cal_y_max_reg;
    logic [RAW_W-1:0]  min_pressure_reg;
    logic [RAW_W-1:0]  max_pressure_reg;
    logic              invert_axes_reg;
    logic [DEB_W-1:0]  debounce_ms_reg;

    top_state_t        state_reg, state_next;
    gesture_t          gesture_reg, gesture_next;
    logic [XW-1:0]     point_x_reg, point_x_next;
    logic [YW-1:0]     point_y_reg, point_y_next;
    logic [RAW_W-1:0]  point_pres_reg, point_pres_next;
    logic              point_ok_reg, point_ok_next;
    logic [TIME_W-1:0] release_reg, release_next;
    logic              out_valid_reg, out_valid_next;

    // word captured at accept
    logic              hit_reg;
    logic [RAW_W-1:0]  pres_reg;
    logic [TIME_W-1:0] now_reg;

    logic              accept;
    logic              hit_in;
    logic              finish;
    logic              x_busy;
    logic              y_busy;
    logic [XW-1:0]     nx;
    logic [YW-1:0]     ny;
    logic [XW:0]       dx;
    logic [YW:0]       dy;
    logic [XW:0]       adx;
    logic [YW:0]       ady;
    logic              moved;
    logic [TIME_W-1:0] elapsed;
    logic              settled;

    assign accept = in_ch.valid && in_ch.ready;
    assign hit_in = in_ch.touched
                 && (in_ch.raw_pressure >= min_pressure_reg)
                 && (in_ch.raw_pressure <= max_pressure_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_x_min_reg    <= RAW_W'(200);
            cal_x_max_reg    <= RAW_W'(3800);
            cal_y_min_reg    <= RAW_W'(200);
            cal_y_max_reg    <= RAW_W'(3800);
            min_pressure_reg <= RAW_W'(200);
            max_pressure_reg <= RAW_W'(4000);
            invert_axes_reg  <= 1'b0;
            debounce_ms_reg  <= DEB_W'(50);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CAL_X_MIN:    cal_x_min_reg    <= cfg_data[RAW_W-1:0];
                CFG_CAL_X_MAX:    cal_x_max_reg    <= cfg_data[RAW_W-1:0];
                CFG_CAL_Y_MIN:    cal_y_min_reg    <= cfg_data[RAW_W-1:0];
                CFG_CAL_Y_MAX:    cal_y_max_reg    <= cfg_data[RAW_W-1:0];
                CFG_MIN_PRESSURE: min_pressure_reg <= cfg_data[RAW_W-1:0];
                CFG_MAX_PRESSURE: max_pressure_reg <= cfg_data[RAW_W-1:0];
                CFG_INVERT_AXES:  invert_axes_reg  <= cfg_data[0];
                CFG_DEBOUNCE_MS:  debounce_ms_reg  <= cfg_data[DEB_W-1:0];
                default:          invert_axes_reg  <= invert_axes_reg;
            endcase
        end
    end

    // both axes map in parallel, each through its own serial divider
    tgq_axis #(
        .SIZE (SCREEN_W)
    ) u_axis_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .raw    (in_ch.raw_x),
        .cal_lo (cal_x_min_reg),
        .cal_hi (cal_x_max_reg),
        .invert (invert_axes_reg),
        .busy   (x_busy),
        .coord  (nx)
    );

    tgq_axis #(
        .SIZE (SCREEN_H)
    ) u_axis_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .raw    (in_ch.raw_y),
        .cal_lo (cal_y_min_reg),
        .cal_hi (cal_y_max_reg),
        .invert (invert_axes_reg),
        .busy   (y_busy),
        .coord  (ny)
    );

    // move detection against the stored point
    assign dx    = {1'b0, nx} - {1'b0, point_x_reg};
    assign dy    = {1'b0, ny} - {1'b0, point_y_reg};
    assign adx   = dx[XW] ? -dx : dx;
    assign ady   = dy[YW] ? -dy : dy;
    assign moved = (adx > (XW+1)'(MOVE_THRESHOLD)) || (ady > (YW+1)'(MOVE_THRESHOLD));

    // modular time since release
    assign elapsed = now_reg - release_reg;
    assign settled = elapsed > TIME_W'(debounce_ms_reg);

    // update only once the previous result has left the output register
    assign finish = (state_reg == T_CALC) && !x_busy && !y_busy
                 && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next      = state_reg;
        gesture_next    = gesture_reg;
        point_x_next    = point_x_reg;
        point_y_next    = point_y_reg;
        point_pres_next = point_pres_reg;
        point_ok_next   = point_ok_reg;
        release_next    = release_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;

        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = T_CALC;
                end
            end
            T_CALC:
            begin
                if (finish)
                begin
                    state_next     = T_IDLE;
                    out_valid_next = 1'b1;
                    case (gesture_reg)
                        G_IDLE:
                        begin
                            if (hit_reg)
                            begin
                                gesture_next = G_DOWN;
                                release_next = now_reg;
                            end
                        end
                        G_DOWN:
                        begin
                            if (hit_reg)
                            begin
                                if (moved)
                                    gesture_next = G_MOVE;
                            end
                            else
                            begin
                                gesture_next = G_UP;
                                release_next = now_reg;
                            end
                        end
                        G_MOVE:
                        begin
                            if (!hit_reg)
                            begin
                                gesture_next = G_UP;
                                release_next = now_reg;
                            end
                        end
                        G_UP:
                        begin
                            // polls are ignored until the hold time runs out
                            if (settled)
                            begin
                                gesture_next  = G_IDLE;
                                point_ok_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            gesture_next = G_IDLE;
                        end
                    endcase
                    // a counted touch outside the up state stores the point
                    if (hit_reg && (gesture_reg != G_UP))
                    begin
                        point_x_next    = nx;
                        point_y_next    = ny;
                        point_pres_next = pres_reg;
                        point_ok_next   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            gesture_reg    <= G_IDLE;
            point_x_reg    <= '0;
            point_y_reg    <= '0;
            point_pres_reg <= '0;
            point_ok_reg   <= 1'b0;
            release_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            gesture_reg    <= gesture_next;
            point_x_reg    <= point_x_next;
            point_y_reg    <= point_y_next;
            point_pres_reg <= point_pres_next;
            point_ok_reg   <= point_ok_next;
            release_reg    <= release_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg  <= hit_in;
            pres_reg <= in_ch.raw_pressure;
            now_reg  <= in_ch.now_ms;
        end
    end

    assign in_ch.ready = (state_reg == T_IDLE);

    // point registers change only when a result is loaded, so they are the payload
    always_comb
    begin
        case (gesture_reg)
            G_IDLE:  out_ch.gesture_state = GS_IDLE;
            G_DOWN:  out_ch.gesture_state = GS_DOWN;
            G_MOVE:  out_ch.gesture_state = GS_MOVE;
            G_UP:    out_ch.gesture_state = GS_UP;
            default: out_ch.gesture_state = GS_IDLE;
        endcase
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.x_pos        = XPOS_W'(point_x_reg);
    assign out_ch.y_pos        = YPOS_W'(point_y_reg);
    assign out_ch.pressure_out = point_pres_reg;
    assign out_ch.point_valid  = point_ok_reg;

    // a fresh result only ever follows a finished calculation
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == T_CALC))
        else $error("result appeared without a calculation");

    // the point is valid exactly outside the idle gesture
    assert property (@(posedge clk) disable iff (!rst_n)
        point_ok_reg == (gesture_reg != G_IDLE))
        else $error("point validity out of step with gesture");

    // axis units are quiet whenever a new word may be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_IDLE) |-> (!x_busy && !y_busy))
        else $error("axis unit busy while idle");

    // stored point stays on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (point_x_reg <= XW'(SCREEN_W - 1)) && (point_y_reg <= YW'(SCREEN_H - 1)))
        else $error("stored point off screen");

endmodule
